### hw/rtl/assert_macros.svh
// Assertion helpers shared by the rate monitor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  `ASSERT_CLK(lbl, clk, rst, !(cond), msg)

`endif

### hw/rtl/prm_pkg.sv
// ----------------------------------------------------------------------------
// prm_pkg
// Types, constants and codes shared by the per-host packet rate monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prm_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int RANGE_COUNT   = 4;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = 1;
  localparam int CFG_IDX_W     = 3;
  localparam int DIV_LANES     = 4;
  localparam int DIV_W         = 48;
  localparam int DIV_CNT_W     = 6;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALERT_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NET_RANGE_0    = 3'd3;

  localparam logic [63:0] RANGE_RESET = 64'hFFFF_FFFF_0000_0000;

  // Result kinds
  localparam logic [1:0] RK_STATUS = 2'd0;
  localparam logic [1:0] RK_ALERT  = 2'd1;
  localparam logic [1:0] RK_FLUSH  = 2'd2;

  // Packet status codes
  localparam logic [1:0] ST_IGNORED = 2'd0;
  localparam logic [1:0] ST_COUNTED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [31:0] src_address;
    logic [31:0] dst_address;
    logic [31:0] now_seconds;
    logic [15:0] captured_bytes;
  } item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  status;
    logic [31:0] host_address;
    logic [31:0] in_packet_rate;
    logic [31:0] out_packet_rate;
    logic [47:0] in_byte_rate;
    logic [47:0] out_byte_rate;
    logic        last;
  } result_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic        flush;
    logic        counted;
    logic        outgoing;
    logic [31:0] addr;
    logic [31:0] now;
    logic [15:0] bytes;
  } cmd_t;

  typedef struct packed {
    logic [31:0] idle_timeout;
    logic [31:0] rate_threshold;
    logic [31:0] alert_interval;
  } cfg_t;

  // One table entry as kept in the counter RAM
  typedef struct packed {
    logic [31:0] last_seen;
    logic [31:0] last_alert;
    logic [31:0] in_packets;
    logic [31:0] out_packets;
    logic [47:0] in_bytes;
    logic [47:0] out_bytes;
  } entry_t;

endpackage

`default_nettype wire

### hw/rtl/prm_ram.sv
// ----------------------------------------------------------------------------
// prm_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/prm_queue.sv
// ----------------------------------------------------------------------------
// prm_queue
// Short command queue between the classifying front and the table back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module prm_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire prm_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output prm_pkg::cmd_t      head,
  output logic               empty,
  output logic               full
);

  prm_pkg::cmd_t                 q [prm_pkg::QUEUE_DEPTH];
  logic [prm_pkg::QPTR_W-1:0]    wr_ptr;
  logic [prm_pkg::QPTR_W-1:0]    rd_ptr;
  logic [prm_pkg::QPTR_W:0]      count;

  assign head  = q[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == (prm_pkg::QPTR_W+1)'(prm_pkg::QUEUE_DEPTH));

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst, push && full && !pop, "queue overflow")
  `ASSERT_NEVER(a_no_underflow, clk, rst, pop && empty, "queue underflow")

endmodule

`default_nettype wire

### hw/rtl/prm_front.sv
// ----------------------------------------------------------------------------
// prm_front
// Configuration registers, item accept and internal range classification.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prm_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire prm_pkg::item_t                  item,
  input  wire logic                            cfg_valid,
  input  wire logic [prm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [63:0]                     cfg_data,
  input  wire logic                            full,
  output logic                                 cfg_ready,
  output logic                                 busy,
  output logic                                 push,
  output prm_pkg::cmd_t                        push_cmd,
  output prm_pkg::cfg_t                        cfg
);

  logic [63:0] net_range [prm_pkg::RANGE_COUNT];
  logic        src_int;
  logic        dst_int;

  assign cfg_ready = 1'b1;
  assign busy      = full;
  assign push      = start && !full;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_timeout   <= 32'd300;
      cfg.rate_threshold <= 32'd10000;
      cfg.alert_interval <= 32'd3600;
      for (int r = 0; r < prm_pkg::RANGE_COUNT; r++) begin
        net_range[r] <= prm_pkg::RANGE_RESET;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        prm_pkg::CFG_IDLE_TIMEOUT:   cfg.idle_timeout   <= cfg_data[31:0];
        prm_pkg::CFG_RATE_THRESHOLD: cfg.rate_threshold <= cfg_data[31:0];
        prm_pkg::CFG_ALERT_INTERVAL: cfg.alert_interval <= cfg_data[31:0];
        default: begin
          for (int r = 0; r < prm_pkg::RANGE_COUNT; r++) begin
            if (cfg_index == prm_pkg::CFG_NET_RANGE_0 + prm_pkg::CFG_IDX_W'(r)) begin
              net_range[r] <= cfg_data;
            end
          end
        end
      endcase
    end
  end

  // Membership in any internal range
  always_comb begin
    src_int = 1'b0;
    dst_int = 1'b0;
    for (int r = 0; r < prm_pkg::RANGE_COUNT; r++) begin
      if (item.src_address >= net_range[r][63:32] &&
          item.src_address <= net_range[r][31:0]) begin
        src_int = 1'b1;
      end
      if (item.dst_address >= net_range[r][63:32] &&
          item.dst_address <= net_range[r][31:0]) begin
        dst_int = 1'b1;
      end
    end
  end

  // Classified command
  always_comb begin
    push_cmd.flush    = item.kind;
    push_cmd.counted  = src_int || dst_int;
    push_cmd.outgoing = src_int;
    push_cmd.addr     = src_int ? item.src_address : item.dst_address;
    push_cmd.now      = item.now_seconds;
    push_cmd.bytes    = item.captured_bytes;
  end

endmodule

`default_nettype wire

### hw/rtl/prm_div.sv
// ----------------------------------------------------------------------------
// prm_div
// Four-lane restoring divider with a shared divisor, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prm_div (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic                                          start,
  input  wire logic [prm_pkg::DIV_LANES-1:0][prm_pkg::DIV_W-1:0] dividend,
  input  wire logic [31:0]                                   divisor,
  output logic                                               done,
  output logic [prm_pkg::DIV_LANES-1:0][prm_pkg::DIV_W-1:0]  quotient
);

  logic [prm_pkg::DIV_LANES-1:0][31:0] rem;
  logic [31:0]                         dvs;
  logic [prm_pkg::DIV_CNT_W-1:0]       cnt;
  logic                                running;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == prm_pkg::DIV_CNT_W'(prm_pkg::DIV_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one dividend bit per lane, subtract when it fits
  always_ff @(posedge clk) begin
    if (start) begin
      dvs      <= divisor;
      rem      <= '0;
      quotient <= dividend;
    end else if (running) begin
      for (int l = 0; l < prm_pkg::DIV_LANES; l++) begin
        logic [32:0] shifted;
        shifted = {rem[l], quotient[l][prm_pkg::DIV_W-1]};
        if (shifted >= {1'b0, dvs}) begin
          rem[l] <= 32'(shifted - {1'b0, dvs});
          quotient[l] <= {quotient[l][prm_pkg::DIV_W-2:0], 1'b1};
        end else begin
          rem[l] <= shifted[31:0];
          quotient[l] <= {quotient[l][prm_pkg::DIV_W-2:0], 1'b0};
        end
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/prm_back.sv
// ----------------------------------------------------------------------------
// prm_back
// Host table: lookup, allocation, counter update and the flush walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module prm_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire prm_pkg::cfg_t  cfg,
  input  wire prm_pkg::cmd_t  head,
  input  wire logic           empty,
  output logic                pop,
  output logic                result_valid,
  output prm_pkg::result_t    result
);

  localparam int SW = prm_pkg::SLOT_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOKUP = 3'd1;
  localparam logic [2:0] S_PKT_WR = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_LOAD   = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_DECIDE = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]                        state;
  prm_pkg::cmd_t                     cmd;
  logic [prm_pkg::TABLE_ENTRIES-1:0] slot_valid;
  logic [31:0]                       slot_address [prm_pkg::TABLE_ENTRIES];
  logic [SW-1:0]                     sel;
  logic                              alloc;
  logic [31:0]                       prev_flush;
  logic [31:0]                       elapsed;
  prm_pkg::entry_t                   entry;

  logic                              hit;
  logic [SW-1:0]                     hit_idx;
  logic                              free_found;
  logic [SW-1:0]                     free_idx;
  logic                              alloc_go;
  logic [31:0]                       head_elapsed;

  logic                              ram_we;
  logic [SW-1:0]                     ram_raddr;
  prm_pkg::entry_t                   ram_wdata;
  logic [$bits(prm_pkg::entry_t)-1:0] ram_rdata;
  prm_pkg::entry_t                   rd_entry;
  prm_pkg::entry_t                   pkt_base;
  prm_pkg::entry_t                   pkt_new;
  prm_pkg::entry_t                   flush_new;

  logic                              div_start;
  logic                              div_done;
  logic [prm_pkg::DIV_LANES-1:0][prm_pkg::DIV_W-1:0] div_q;
  logic                              alert;
  logic                              idle_out;
  logic                              scan_end;
  logic [48:0]                       byte_sum;

  // Final result of an item: rates zero, last set
  function automatic prm_pkg::result_t plain_result(logic [1:0]  kind,
                                                    logic [1:0]  st,
                                                    logic [31:0] host);
    prm_pkg::result_t r;
    r              = '0;
    r.result_kind  = kind;
    r.status       = st;
    r.host_address = host;
    r.last         = 1'b1;
    return r;
  endfunction

  assign rd_entry = prm_pkg::entry_t'(ram_rdata);
  assign pop      = (state == S_IDLE) && !empty;
  assign alloc_go = (state == S_LOOKUP) && !hit && free_found;
  assign scan_end = (sel == SW'(prm_pkg::TABLE_ENTRIES - 1));

  // Associative lookup and lowest free slot
  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = prm_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_address[i] == cmd.addr) begin
        hit     = 1'b1;
        hit_idx = SW'(i);
      end
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  // Elapsed time of a flush, zero taken as one
  always_comb begin
    head_elapsed = head.now - prev_flush;
    if (head_elapsed == '0) begin
      head_elapsed = 32'd1;
    end
  end

  // Packet update of one entry; a fresh slot starts from zero
  always_comb begin
    pkt_base = alloc ? '0 : rd_entry;
    pkt_new  = pkt_base;
    pkt_new.last_seen = cmd.now;
    byte_sum = {1'b0, (cmd.outgoing ? pkt_base.out_bytes : pkt_base.in_bytes)}
             + {33'd0, cmd.bytes};
    if (cmd.outgoing) begin
      if (pkt_base.out_packets != '1) begin
        pkt_new.out_packets = pkt_base.out_packets + 32'd1;
      end
      pkt_new.out_bytes = byte_sum[48] ? '1 : byte_sum[47:0];
    end else begin
      if (pkt_base.in_packets != '1) begin
        pkt_new.in_packets = pkt_base.in_packets + 32'd1;
      end
      pkt_new.in_bytes = byte_sum[48] ? '1 : byte_sum[47:0];
    end
  end

  // Flush decision on the loaded entry
  always_comb begin
    alert = (div_q[0][31:0] >= cfg.rate_threshold ||
             div_q[1][31:0] >= cfg.rate_threshold) &&
            ((cmd.now - entry.last_alert) >= cfg.alert_interval);
    idle_out = (cmd.now - entry.last_seen) >= cfg.idle_timeout;
    flush_new             = entry;
    flush_new.in_packets  = '0;
    flush_new.out_packets = '0;
    flush_new.in_bytes    = '0;
    flush_new.out_bytes   = '0;
    if (alert) begin
      flush_new.last_alert = cmd.now;
    end
  end

  // RAM port selection
  always_comb begin
    ram_raddr = (state == S_LOOKUP) ? (hit ? hit_idx : free_idx) : sel;
    ram_we    = (state == S_PKT_WR) || (state == S_DECIDE);
    ram_wdata = (state == S_PKT_WR) ? pkt_new : flush_new;
  end

  assign div_start = (state == S_LOAD);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      slot_valid   <= '0;
      prev_flush   <= '0;
      result_valid <= 1'b0;
      alloc        <= 1'b0;
      sel          <= '0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!empty) begin
            cmd <= head;
            if (head.flush) begin
              elapsed <= head_elapsed;
              sel     <= '0;
              state   <= S_SCAN;
            end else if (head.counted) begin
              state <= S_LOOKUP;
            end else begin
              result_valid <= 1'b1;
              result       <= plain_result(prm_pkg::RK_STATUS, prm_pkg::ST_IGNORED, '0);
            end
          end
        end
        S_LOOKUP: begin
          if (hit) begin
            sel   <= hit_idx;
            alloc <= 1'b0;
            state <= S_PKT_WR;
          end else if (free_found) begin
            sel   <= free_idx;
            alloc <= 1'b1;
            slot_valid[free_idx]   <= 1'b1;
            slot_address[free_idx] <= cmd.addr;
            state <= S_PKT_WR;
          end else begin
            result_valid <= 1'b1;
            result       <= plain_result(prm_pkg::RK_STATUS, prm_pkg::ST_FULL, cmd.addr);
            state <= S_IDLE;
          end
        end
        S_PKT_WR: begin
          result_valid <= 1'b1;
          result       <= plain_result(prm_pkg::RK_STATUS, prm_pkg::ST_COUNTED, cmd.addr);
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (slot_valid[sel]) begin
            state <= S_LOAD;
          end else if (scan_end) begin
            state <= S_DONE;
          end else begin
            sel <= sel + 1'b1;
          end
        end
        S_LOAD: begin
          entry <= rd_entry;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (alert) begin
            result_valid <= 1'b1;
            result.result_kind     <= prm_pkg::RK_ALERT;
            result.status          <= prm_pkg::ST_IGNORED;
            result.host_address    <= slot_address[sel];
            result.in_packet_rate  <= div_q[0][31:0];
            result.out_packet_rate <= div_q[1][31:0];
            result.in_byte_rate    <= div_q[2];
            result.out_byte_rate   <= div_q[3];
            result.last            <= 1'b0;
          end
          if (idle_out) begin
            slot_valid[sel] <= 1'b0;
          end
          if (scan_end) begin
            state <= S_DONE;
          end else begin
            sel   <= sel + 1'b1;
            state <= S_SCAN;
          end
        end
        S_DONE: begin
          result_valid <= 1'b1;
          result       <= plain_result(prm_pkg::RK_FLUSH, prm_pkg::ST_IGNORED, '0);
          prev_flush <= cmd.now;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  prm_ram #(
    .WIDTH ($bits(prm_pkg::entry_t)),
    .DEPTH (prm_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sel),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  prm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({rd_entry.out_bytes, rd_entry.in_bytes,
                16'd0, rd_entry.out_packets, 16'd0, rd_entry.in_packets}),
    .divisor  (elapsed),
    .done     (div_done),
    .quotient (div_q)
  );

  `ASSERT_CLK(a_alloc_grows, clk, rst,
    alloc_go |=> ($countones(slot_valid) == $past($countones(slot_valid)) + 1),
    "allocation did not take exactly one free slot")
  `ASSERT_CLK(a_div_only_in_flush, clk, rst,
    div_done |-> (state == S_DIV), "divider finished outside the flush walk")

endmodule

`default_nettype wire

### hw/rtl/per_host_packet_rate_monitor.sv
// ----------------------------------------------------------------------------
// per_host_packet_rate_monitor
// Per-address packet and byte counters with periodic rate alerts.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start/item and are taken when start is high and busy low.
//   A two-entry queue sits between the classifier and the table engine, so
//   busy rises only when both queue entries are waiting.
//   Results leave on result/result_valid, one cycle each; the receiver
//   cannot stall, so no backpressure exists on this side.
//   Registers are written on cfg_valid/cfg_ready (ready is always high);
//   the user must write them only while the block is idle; it does not check.
// Operation:
//   A counted packet passes the table engine's dequeue, lookup and
//   read-modify-write of the counter RAM; an ignored packet only the dequeue.
//   Its status result is registered in the last step it passes.
//   A flush visits all 32 slots; a free slot is only checked, while a valid
//   slot is loaded, divided by the 48-step bit-serial divider, written back.
// Reset:
//   rst (synchronous) empties the table, clears the last flush time and
//   loads the register reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module per_host_packet_rate_monitor (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire prm_pkg::item_t                item,
  output logic                               result_valid,
  output prm_pkg::result_t                   result,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [prm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]                   cfg_data
);

  logic          push;
  logic          pop;
  logic          empty;
  logic          full;
  prm_pkg::cmd_t push_cmd;
  prm_pkg::cmd_t head;
  prm_pkg::cfg_t cfg;

  prm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .full      (full),
    .cfg_ready (cfg_ready),
    .busy      (busy),
    .push      (push),
    .push_cmd  (push_cmd),
    .cfg       (cfg)
  );

  prm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  prm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire
